// ===== hw/rtl/dmg_pkg.sv =====
// shared types, constants and helper functions of the maze generator
`default_nettype none

package dmg_pkg;

	localparam int CFG_DIM_W = 6;
	localparam int SEED_W = 32;
	localparam int CFG_IDX_W = 2;
	localparam int COORD_W = 5;
	localparam int WALLS_W = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RANDOM_SEED = 2'd2;

	localparam logic [CFG_DIM_W-1:0] GRID_DIM_RESET = 6'd16;
	localparam logic [SEED_W-1:0] SEED_RESET = 32'd1;
	localparam logic [SEED_W-1:0] LFSR_MASK = 32'h8020_0003;

	localparam logic OP_GENERATE = 1'b0;
	localparam logic OP_READ = 1'b1;

	// wall bits: top, left, right, down
	localparam logic [WALLS_W-1:0] WALL_TOP = 4'b0001;
	localparam logic [WALLS_W-1:0] WALL_LEFT = 4'b0010;
	localparam logic [WALLS_W-1:0] WALL_RIGHT = 4'b0100;
	localparam logic [WALLS_W-1:0] WALL_DOWN = 4'b1000;
	localparam logic [WALLS_W-1:0] WALLS_ALL = 4'b1111;

	// neighbour order of the search
	typedef enum logic [1:0] {
		DIR_LEFT,
		DIR_RIGHT,
		DIR_UP,
		DIR_DOWN
	} dir_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD_WALLS,
		ST_INIT,
		ST_SCAN,
		ST_PICK,
		ST_WR_CUR,
		ST_WR_NB,
		ST_POP,
		ST_POP_WAIT,
		ST_FINISH
	} dmg_state_t;

	typedef struct packed {
		logic visited;
		logic [WALLS_W-1:0] walls;
	} cell_t;

	typedef struct packed {
		logic opcode;
		logic [COORD_W-1:0] cell_x;
		logic [COORD_W-1:0] cell_y;
	} dmg_cmd_t;

	typedef struct packed {
		logic [COORD_W-1:0] end_x;
		logic [COORD_W-1:0] end_y;
		logic wall_top;
		logic wall_left;
		logic wall_right;
		logic wall_down;
		logic out_of_range;
	} dmg_res_t;

	function automatic logic [SEED_W-1:0] lfsr_step(input logic [SEED_W-1:0] v);
		logic [SEED_W-1:0] r;
		r = v >> 1;
		if (v[0]) begin
			r = r ^ LFSR_MASK;
		end
		return r;
	endfunction

	// 4 is 1 mod 3, so the base-4 digit sum keeps the residue
	function automatic logic [1:0] mod3_32(input logic [SEED_W-1:0] v);
		logic [2:0] l1 [8];
		logic [3:0] l2 [4];
		logic [4:0] l3 [2];
		logic [5:0] s;
		logic [3:0] t;
		logic [1:0] r;
		for (int i = 0; i < 8; i++) begin
			l1[i] = {1'b0, v[4*i +: 2]} + {1'b0, v[4*i+2 +: 2]};
		end
		for (int i = 0; i < 4; i++) begin
			l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
		end
		for (int i = 0; i < 2; i++) begin
			l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
		end
		s = {1'b0, l3[0]} + {1'b0, l3[1]};
		t = {2'b00, s[5:4]} + {2'b00, s[3:2]} + {2'b00, s[1:0]};
		case (t) inside
			4'd1, 4'd4, 4'd7: r = 2'd1;
			4'd2, 4'd5, 4'd8: r = 2'd2;
			default: r = 2'd0;
		endcase
		return r;
	endfunction

	// lfsr value modulo the candidate count
	function automatic logic [1:0] pick_index(input logic [SEED_W-1:0] v, input logic [2:0] n);
		logic [1:0] k;
		case (n)
			3'd2: k = {1'b0, v[0]};
			3'd3: k = mod3_32(v);
			3'd4: k = v[1:0];
			default: k = 2'd0;
		endcase
		return k;
	endfunction

	// position of the k-th set bit of the candidate mask
	function automatic dir_t kth_set(input logic [3:0] m, input logic [1:0] k);
		logic [1:0] cnt;
		dir_t d;
		cnt = 2'd0;
		d = DIR_LEFT;
		for (int j = 0; j < 4; j++) begin
			if (m[j]) begin
				if (cnt == k) begin
					d = dir_t'(2'(j));
				end
				cnt = cnt + 2'd1;
			end
		end
		return d;
	endfunction

	function automatic logic [WALLS_W-1:0] dir_wall(input dir_t d);
		logic [WALLS_W-1:0] w;
		unique case (d)
			DIR_LEFT: w = WALL_LEFT;
			DIR_RIGHT: w = WALL_RIGHT;
			DIR_UP: w = WALL_TOP;
			DIR_DOWN: w = WALL_DOWN;
			default: w = WALL_TOP;
		endcase
		return w;
	endfunction

	function automatic logic [WALLS_W-1:0] opp_wall(input dir_t d);
		logic [WALLS_W-1:0] w;
		unique case (d)
			DIR_LEFT: w = WALL_RIGHT;
			DIR_RIGHT: w = WALL_LEFT;
			DIR_UP: w = WALL_DOWN;
			DIR_DOWN: w = WALL_TOP;
			default: w = WALL_TOP;
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/dmg_stream_if.sv =====
// valid/ready stream channel with a typed payload
`default_nettype none

interface dmg_stream_if #(
	parameter type payload_t = logic
);
	logic valid;
	logic ready;
	payload_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/dfs_maze_generator.sv =====
// Randomized depth-first maze generator over a grid held in on-chip memory.
// A generate item clears the whole cell memory (the same pass runs once after
// reset, with cmd.ready low) and then carves from the start cell. Every carve
// or backtrack step runs a scan (five reads of the cell memory through its
// single read port, the cell and its four neighbours, with one more scan phase
// for the last data to return), a pick, and then the two writes of a carve or
// the stack read of a backtrack.
// A read item passes through the wall read and the finish state, a cell
// outside the grid goes from idle straight to the finish state. One item is
// worked at a time; a finished result waits in the output register while the
// next item is taken.
`default_nettype none

module dfs_maze_generator #(
	parameter int MAX_WIDTH = 32,
	parameter int MAX_HEIGHT = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [dmg_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [dmg_pkg::SEED_W-1:0] cfg_data,
	dmg_stream_if.sink cmd,
	dmg_stream_if.source res
);

	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);
	localparam int AW = XW + YW;
	localparam int DEPTH = 1 << AW;
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int NW = WW + HW;

	// configuration
	logic [dmg_pkg::CFG_DIM_W-1:0] grid_width_q;
	logic [dmg_pkg::CFG_DIM_W-1:0] grid_height_q;
	logic [dmg_pkg::SEED_W-1:0] random_seed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q <= dmg_pkg::GRID_DIM_RESET;
			grid_height_q <= dmg_pkg::GRID_DIM_RESET;
			random_seed_q <= dmg_pkg::SEED_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				dmg_pkg::CFG_GRID_WIDTH: grid_width_q <= cfg_data[dmg_pkg::CFG_DIM_W-1:0];
				dmg_pkg::CFG_GRID_HEIGHT: grid_height_q <= cfg_data[dmg_pkg::CFG_DIM_W-1:0];
				dmg_pkg::CFG_RANDOM_SEED: random_seed_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [WW-1:0] eff_w;
	logic [HW-1:0] eff_h;

	always_comb begin
		if (grid_width_q == '0) begin
			eff_w = WW'(1);
		end else if (32'(grid_width_q) > 32'(MAX_WIDTH)) begin
			eff_w = WW'(MAX_WIDTH);
		end else begin
			eff_w = WW'(grid_width_q);
		end
		if (grid_height_q == '0) begin
			eff_h = HW'(1);
		end else if (32'(grid_height_q) > 32'(MAX_HEIGHT)) begin
			eff_h = HW'(MAX_HEIGHT);
		end else begin
			eff_h = HW'(grid_height_q);
		end
	end

	// state and datapath registers
	dmg_pkg::dmg_state_t state_q, state_d;
	logic [AW-1:0] clr_q;
	logic gen_q;
	logic op_q;
	logic oor_q;
	logic [XW-1:0] start_x_q;
	logic [YW-1:0] start_y_q;
	logic [XW-1:0] cx_q;
	logic [YW-1:0] cy_q;
	logic [2:0] phase_q;
	logic [dmg_pkg::WALLS_W-1:0] cur_walls_q;
	dmg_pkg::cell_t nb_q [4];
	dmg_pkg::dir_t dir_q;
	logic [dmg_pkg::SEED_W-1:0] lfsr_q;
	logic [NW-1:0] depth_q;
	logic [NW-1:0] visited_q;
	logic [NW-1:0] total_q;
	logic [NW-1:0] far_depth_q;
	logic [XW-1:0] far_x_q;
	logic [YW-1:0] far_y_q;
	logic out_valid_q;
	dmg_pkg::dmg_res_t out_data_q;
	logic res_load;
	dmg_pkg::dmg_res_t res_d;

	// memories
	dmg_pkg::cell_t cell_mem [DEPTH];
	dmg_pkg::cell_t cm_rdata_q;
	logic cm_we;
	logic [AW-1:0] cm_waddr;
	logic [AW-1:0] cm_raddr;
	dmg_pkg::cell_t cm_wdata;

	logic [AW-1:0] stk_mem [DEPTH];
	logic [AW-1:0] stk_rdata_q;
	logic stk_we;
	logic [AW-1:0] stk_raddr;

	always_ff @(posedge clk) begin
		if (cm_we) begin
			cell_mem[cm_waddr] <= cm_wdata;
		end
		cm_rdata_q <= cell_mem[cm_raddr];
	end

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem[depth_q[AW-1:0]] <= {cy_q, cx_q};
		end
		stk_rdata_q <= stk_mem[stk_raddr];
	end

	// input decode
	logic cmd_fire;
	logic cmd_oor;
	logic [XW-1:0] cmd_x;
	logic [YW-1:0] cmd_y;
	logic out_free;

	assign cmd.ready = (state_q == dmg_pkg::ST_IDLE);
	assign cmd_fire = cmd.valid && cmd.ready;
	assign cmd_oor = (32'(cmd.data.cell_x) >= 32'(eff_w)) ||
		(32'(cmd.data.cell_y) >= 32'(eff_h));
	assign cmd_x = XW'(cmd.data.cell_x);
	assign cmd_y = YW'(cmd.data.cell_y);
	assign out_free = !out_valid_q || res.ready;
	assign res_load = (state_q == dmg_pkg::ST_FINISH) && out_free;

	// candidate neighbours, in search order
	logic [3:0] in_grid;
	logic [3:0] cand;
	logic [2:0] cand_n;
	logic [dmg_pkg::SEED_W-1:0] lfsr_nxt;
	logic [XW-1:0] nb_x;
	logic [YW-1:0] nb_y;
	logic [NW-1:0] depth_dec;

	assign in_grid[dmg_pkg::DIR_LEFT] = (cx_q != '0);
	assign in_grid[dmg_pkg::DIR_RIGHT] = (32'(cx_q) + 32'd1 < 32'(eff_w));
	assign in_grid[dmg_pkg::DIR_UP] = (cy_q != '0);
	assign in_grid[dmg_pkg::DIR_DOWN] = (32'(cy_q) + 32'd1 < 32'(eff_h));

	always_comb begin
		for (int j = 0; j < 4; j++) begin
			cand[j] = in_grid[j] && !nb_q[j].visited;
		end
	end

	assign cand_n = 3'($countones(cand));
	assign lfsr_nxt = dmg_pkg::lfsr_step(lfsr_q);
	assign depth_dec = depth_q - NW'(1);

	always_comb begin
		nb_x = cx_q;
		nb_y = cy_q;
		unique case (dir_q)
			dmg_pkg::DIR_LEFT: nb_x = cx_q - XW'(1);
			dmg_pkg::DIR_RIGHT: nb_x = cx_q + XW'(1);
			dmg_pkg::DIR_UP: nb_y = cy_q - YW'(1);
			dmg_pkg::DIR_DOWN: nb_y = cy_q + YW'(1);
			default: ;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dmg_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and memory controls
	always_comb begin
		state_d = state_q;
		cm_we = 1'b0;
		cm_waddr = {cy_q, cx_q};
		cm_wdata = '{visited: 1'b0, walls: dmg_pkg::WALLS_ALL};
		cm_raddr = {cy_q, cx_q};
		stk_we = 1'b0;
		stk_raddr = depth_dec[AW-1:0];
		unique case (state_q)
			dmg_pkg::ST_CLEAR: begin
				cm_we = 1'b1;
				cm_waddr = clr_q;
				if (clr_q == AW'(DEPTH - 1)) begin
					state_d = gen_q ? dmg_pkg::ST_INIT : dmg_pkg::ST_IDLE;
				end
			end
			dmg_pkg::ST_IDLE: begin
				cm_raddr = {cmd_y, cmd_x};
				if (cmd_fire) begin
					if (cmd_oor) begin
						state_d = dmg_pkg::ST_FINISH;
					end else if (cmd.data.opcode == dmg_pkg::OP_READ) begin
						state_d = dmg_pkg::ST_RD_WALLS;
					end else begin
						state_d = dmg_pkg::ST_CLEAR;
					end
				end
			end
			dmg_pkg::ST_RD_WALLS: begin
				state_d = dmg_pkg::ST_FINISH;
			end
			dmg_pkg::ST_INIT: begin
				cm_we = 1'b1;
				cm_waddr = {start_y_q, start_x_q};
				cm_wdata = '{visited: 1'b1, walls: dmg_pkg::WALLS_ALL};
				state_d = dmg_pkg::ST_SCAN;
			end
			dmg_pkg::ST_SCAN: begin
				// one read issued per phase, its data arrives in the next one
				unique case (phase_q)
					3'd1: cm_raddr = {cy_q, cx_q - XW'(1)};
					3'd2: cm_raddr = {cy_q, cx_q + XW'(1)};
					3'd3: cm_raddr = {cy_q - YW'(1), cx_q};
					3'd4: cm_raddr = {cy_q + YW'(1), cx_q};
					default: cm_raddr = {cy_q, cx_q};
				endcase
				if (phase_q == 3'd0 && visited_q == total_q) begin
					state_d = dmg_pkg::ST_FINISH;
				end else if (phase_q == 3'd5) begin
					state_d = dmg_pkg::ST_PICK;
				end
			end
			dmg_pkg::ST_PICK: begin
				if (cand_n != 3'd0) begin
					state_d = dmg_pkg::ST_WR_CUR;
				end else if (depth_q != '0) begin
					state_d = dmg_pkg::ST_POP;
				end else begin
					state_d = dmg_pkg::ST_FINISH;
				end
			end
			dmg_pkg::ST_WR_CUR: begin
				cm_we = 1'b1;
				cm_waddr = {cy_q, cx_q};
				cm_wdata = '{visited: 1'b1,
					walls: cur_walls_q & ~dmg_pkg::dir_wall(dir_q)};
				stk_we = 1'b1;
				state_d = dmg_pkg::ST_WR_NB;
			end
			dmg_pkg::ST_WR_NB: begin
				cm_we = 1'b1;
				cm_waddr = {nb_y, nb_x};
				cm_wdata = '{visited: 1'b1,
					walls: nb_q[dir_q].walls & ~dmg_pkg::opp_wall(dir_q)};
				state_d = dmg_pkg::ST_SCAN;
			end
			dmg_pkg::ST_POP: begin
				state_d = dmg_pkg::ST_POP_WAIT;
			end
			dmg_pkg::ST_POP_WAIT: begin
				state_d = dmg_pkg::ST_SCAN;
			end
			dmg_pkg::ST_FINISH: begin
				if (out_free) begin
					state_d = dmg_pkg::ST_IDLE;
				end
			end
			default: state_d = dmg_pkg::ST_IDLE;
		endcase
	end

	// control and carve registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			gen_q <= 1'b0;
			phase_q <= '0;
			lfsr_q <= dmg_pkg::SEED_RESET;
			depth_q <= '0;
			visited_q <= '0;
			total_q <= '0;
			far_depth_q <= '0;
			far_x_q <= '0;
			far_y_q <= '0;
			cx_q <= '0;
			cy_q <= '0;
			dir_q <= dmg_pkg::DIR_LEFT;
			out_valid_q <= 1'b0;
		end else begin
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				dmg_pkg::ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
				end
				dmg_pkg::ST_IDLE: begin
					gen_q <= cmd_fire && !cmd_oor && (cmd.data.opcode == dmg_pkg::OP_GENERATE);
				end
				dmg_pkg::ST_INIT: begin
					gen_q <= 1'b0;
					lfsr_q <= (random_seed_q != '0) ? random_seed_q : dmg_pkg::SEED_RESET;
					depth_q <= '0;
					visited_q <= NW'(1);
					total_q <= NW'(eff_w) * NW'(eff_h);
					far_depth_q <= '0;
					far_x_q <= start_x_q;
					far_y_q <= start_y_q;
					cx_q <= start_x_q;
					cy_q <= start_y_q;
					phase_q <= '0;
				end
				dmg_pkg::ST_SCAN: begin
					phase_q <= (phase_q == 3'd5) ? 3'd0 : phase_q + 3'd1;
				end
				dmg_pkg::ST_PICK: begin
					if (cand_n != 3'd0) begin
						lfsr_q <= lfsr_nxt;
						dir_q <= dmg_pkg::kth_set(cand, dmg_pkg::pick_index(lfsr_nxt, cand_n));
					end
				end
				dmg_pkg::ST_WR_CUR: begin
					depth_q <= depth_q + NW'(1);
				end
				dmg_pkg::ST_WR_NB: begin
					cx_q <= nb_x;
					cy_q <= nb_y;
					visited_q <= visited_q + NW'(1);
					if (depth_q > far_depth_q) begin
						far_depth_q <= depth_q;
						far_x_q <= nb_x;
						far_y_q <= nb_y;
					end
				end
				dmg_pkg::ST_POP: begin
					depth_q <= depth_dec;
				end
				dmg_pkg::ST_POP_WAIT: begin
					{cy_q, cx_q} <= stk_rdata_q;
				end
				default: ;
			endcase
		end
	end

	// result of the finished item
	always_comb begin
		res_d = '0;
		if (oor_q) begin
			res_d.out_of_range = 1'b1;
		end else if (op_q == dmg_pkg::OP_READ) begin
			res_d.wall_top = |(cur_walls_q & dmg_pkg::WALL_TOP);
			res_d.wall_left = |(cur_walls_q & dmg_pkg::WALL_LEFT);
			res_d.wall_right = |(cur_walls_q & dmg_pkg::WALL_RIGHT);
			res_d.wall_down = |(cur_walls_q & dmg_pkg::WALL_DOWN);
		end else begin
			res_d.end_x = dmg_pkg::COORD_W'(far_x_q);
			res_d.end_y = dmg_pkg::COORD_W'(far_y_q);
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			op_q <= cmd.data.opcode;
			oor_q <= cmd_oor;
			start_x_q <= cmd_x;
			start_y_q <= cmd_y;
		end
		if (state_q == dmg_pkg::ST_RD_WALLS) begin
			cur_walls_q <= cm_rdata_q.walls;
		end
		if (state_q == dmg_pkg::ST_SCAN) begin
			unique case (phase_q)
				3'd1: cur_walls_q <= cm_rdata_q.walls;
				3'd2: nb_q[0] <= cm_rdata_q;
				3'd3: nb_q[1] <= cm_rdata_q;
				3'd4: nb_q[2] <= cm_rdata_q;
				3'd5: nb_q[3] <= cm_rdata_q;
				default: ;
			endcase
		end
		if (res_load) begin
			out_data_q <= res_d;
		end
	end

	assign res.valid = out_valid_q;
	assign res.data = out_data_q;

	// checks
	a_depth_le_visited: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= visited_q)
		else $error("stack deeper than visited cell count");

	a_visited_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		visited_q <= total_q)
		else $error("visited count beyond grid size");

	a_carve_to_candidate: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == dmg_pkg::ST_WR_CUR |-> cand[dir_q])
		else $error("carving toward a visited or off-grid neighbour");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == dmg_pkg::ST_POP |-> depth_q != '0)
		else $error("pop from an empty stack");

	a_clear_before_init: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == dmg_pkg::ST_INIT |-> $past(state_q) == dmg_pkg::ST_CLEAR)
		else $error("carving started without a clearing pass");

endmodule

`default_nettype wire
